// ===== rtl/mtae_pkg.sv =====
`default_nettype none
package mtae_pkg;

    localparam int KEYWORD_COUNT = 39;
    localparam int KW_MAX        = 17;

    // Index of the closing keyword "/" in the keyword table.
    localparam logic [5:0] KW_CLOSE = 6'd0;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_UNCLOSED  = 3'd1;
    localparam logic [2:0] ST_UNKNOWN   = 3'd2;
    localparam logic [2:0] ST_CLOSE_BAD = 3'd3;
    localparam logic [2:0] ST_OPEN_END  = 3'd4;

    localparam logic [7:0] CH_ESC   = 8'h1B;
    localparam logic [7:0] CH_OPEN  = 8'h5B;
    localparam logic [7:0] CH_CLOSE = 8'h5D;
    localparam logic [7:0] CH_M     = 8'h6D;

    // One classified job handed from the front end to the back end.
    // kind selects how the back end expands it into output bytes.
    localparam logic [2:0] JOB_BYTE   = 3'd0; // one literal byte (b0)
    localparam logic [2:0] JOB_PAIR   = 3'd1; // '[' then b0
    localparam logic [2:0] JOB_ESC    = 3'd2; // escape sequence with code
    localparam logic [2:0] JOB_STATUS = 3'd3; // status-only result
    localparam logic [2:0] JOB_QUIET  = 3'd4; // no byte results

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] b0;
        logic [2:0] code_len;   // 1..4 code characters
        logic [31:0] code;      // code chars, first in low byte
        logic [2:0] err;        // status-only code (kind JOB_STATUS)
        logic       open_end;   // append status-4 result
        logic       last;       // final input of message
    } mtae_job_t;

    // Keyword text, first char in low byte, zero filled.
    function automatic logic [135:0] kw_word(input int idx);
        case (idx)
            0: kw_word = "/";
            1: kw_word = "REBMUN";
            2: kw_word = "DLOB";
            3: kw_word = "MID";
            4: kw_word = "CILATI";
            5: kw_word = "REDNU";
            6: kw_word = "EKIRTS";
            7: kw_word = "KCALB";
            8: kw_word = "KCALB-THGIRB";
            9: kw_word = "KCALB NO";
            10: kw_word = "KCALB-THGIRB NO";
            11: kw_word = "DER";
            12: kw_word = "DER-THGIRB";
            13: kw_word = "DER NO";
            14: kw_word = "DER-THGIRB NO";
            15: kw_word = "NEERG";
            16: kw_word = "NEERG-THGIRB";
            17: kw_word = "NEERG NO";
            18: kw_word = "NEERG-THGIRB NO";
            19: kw_word = "WOLLEY";
            20: kw_word = "WOLLEY-THGIRB";
            21: kw_word = "WOLLEY NO";
            22: kw_word = "WOLLEY-THGIRB NO";
            23: kw_word = "EULB";
            24: kw_word = "EULB-THGIRB";
            25: kw_word = "EULB NO";
            26: kw_word = "EULB-THGIRB NO";
            27: kw_word = "ATNEGAM";
            28: kw_word = "ATNEGAM-THGIRB";
            29: kw_word = "ATNEGAM NO";
            30: kw_word = "ATNEGAM-THGIRB NO";
            31: kw_word = "NAYC";
            32: kw_word = "NAYC-THGIRB";
            33: kw_word = "NAYC NO";
            34: kw_word = "NAYC-THGIRB NO";
            35: kw_word = "ETIHW";
            36: kw_word = "ETIHW-THGIRB";
            37: kw_word = "ETIHW NO";
            default: kw_word = "ETIHW-THGIRB NO";
        endcase
    endfunction

    function automatic logic [4:0] kw_len(input int idx);
        case (idx) inside
            0: kw_len = 5'd1;
            1, 4, 6, 13, 19: kw_len = 5'd6;
            2, 23, 31: kw_len = 5'd4;
            3, 11: kw_len = 5'd3;
            5, 7, 15, 35: kw_len = 5'd5;
            8, 16, 36: kw_len = 5'd12;
            9, 17, 37: kw_len = 5'd8;
            10, 18, 38: kw_len = 5'd15;
            12, 29: kw_len = 5'd10;
            14, 20: kw_len = 5'd13;
            21: kw_len = 5'd9;
            22: kw_len = 5'd16;
            24, 32: kw_len = 5'd11;
            26, 28, 34: kw_len = 5'd14;
            30: kw_len = 5'd17;
            default: kw_len = 5'd7;
        endcase
    endfunction

    // Escape code text (low byte first) and its length.
    function automatic logic [34:0] kw_code(input int idx);
        logic [7:0] d;
        d = 8'h30 + 8'((idx - 7) / 4);
        case (idx)
            0: kw_code = {3'd1, 32'h00000030};
            1: kw_code = {3'd4, 32'h36333B31};
            2: kw_code = {3'd1, 32'h00000031};
            3: kw_code = {3'd1, 32'h00000032};
            4: kw_code = {3'd1, 32'h00000033};
            5: kw_code = {3'd1, 32'h00000034};
            6: kw_code = {3'd1, 32'h00000039};
            default:
            begin
                case ((idx - 7) % 4)
                    0: kw_code = {3'd2, 16'h0000, d, 8'h33};
                    1: kw_code = {3'd2, 16'h0000, d, 8'h39};
                    2: kw_code = {3'd2, 16'h0000, d, 8'h34};
                    default: kw_code = {3'd3, 8'h00, d, 8'h30, 8'h31};
                endcase
            end
        endcase
    endfunction

endpackage
`default_nettype wire

// ===== rtl/markup_tag_to_ansi_escape.sv =====
// A job queued while the queue is empty offers its first result in the following cycle.
// Throughput: one input byte per cycle while each byte gives at most one result and the
// output is ready; each result of a job is one transfer (escape 4 to 7, 8 with open-at-end).
// The QUEUE_DEPTH-entry job queue (four by default) absorbs bursts; input stalls when full.
// Reset (rst_n, asynchronous, low) clears tag, span, error state, queue and strip mode;
// held tag text is not cleared, only bytes written in the current tag are compared.
`default_nettype none
module markup_tag_to_ansi_escape #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic        cfg_wdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  wire logic        s_axis_tlast,   // msg_last
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [7:0] out_byte, [8] msg_end
    output logic [3:0]       m_axis_tuser,   // [0] byte_valid, [3:1] status
    output logic             m_axis_tlast    // run_last
);
    logic                strip_mode_reg;
    logic                job_valid;
    logic                job_full;
    mtae_pkg::mtae_job_t job;

    // Hold the mode register; the user must write it only while idle, the block does not enforce this.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            strip_mode_reg <= 1'b0;
        else if (cfg_we)
            strip_mode_reg <= cfg_wdata;
    end

    // Front end: classify each transfer and match tags.
    mtae_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .strip_mode (strip_mode_reg),
        .in_valid   (s_axis_tvalid),
        .in_byte    (s_axis_tdata),
        .in_last    (s_axis_tlast),
        .in_ready   (s_axis_tready),
        .job_valid  (job_valid),
        .job        (job),
        .job_full   (job_full)
    );

    // Back end: queue jobs and expand them into output transfers.
    mtae_back #(.DEPTH(QUEUE_DEPTH)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job       (job),
        .job_full  (job_full),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_user  (m_axis_tuser),
        .out_last  (m_axis_tlast)
    );

endmodule
`default_nettype wire

// ===== rtl/mtae_front.sv =====
`default_nettype none
module mtae_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               strip_mode,
    input  wire logic               in_valid,
    input  wire logic [7:0]         in_byte,
    input  wire logic               in_last,
    output logic                    in_ready,
    output logic                    job_valid,
    output mtae_pkg::mtae_job_t     job,
    input  wire logic               job_full
);
    logic [7:0] text_reg [mtae_pkg::KW_MAX];
    logic [4:0] count_reg;
    logic       in_tag_reg;
    logic       span_reg;
    logic       err_reg;
    logic       take;
    logic       hit;
    logic [5:0] hit_idx;
    logic [34:0] cdata;
    logic [7:0] b;

    assign in_ready = !job_full;
    assign take = in_valid && in_ready;
    assign b = in_byte;

    always_comb
    begin
        logic [135:0] w;
        logic         eq;
        hit = 1'b0;
        hit_idx = mtae_pkg::KW_CLOSE;
        cdata = '0;
        for (int k = 0; k < mtae_pkg::KEYWORD_COUNT; k++)
        begin
            w = mtae_pkg::kw_word(k);
            eq = (mtae_pkg::kw_len(k) == count_reg);
            for (int j = 0; j < mtae_pkg::KW_MAX; j++)
            begin
                if (5'(j) < count_reg && w[j*8 +: 8] != text_reg[j])
                begin
                    eq = 1'b0;
                end
            end
            if (eq && !hit)
            begin
                hit = 1'b1;
                hit_idx = 6'(k);
                cdata = mtae_pkg::kw_code(k);
            end
        end
    end

    always_comb
    begin
        logic span_after;
        logic err_after;
        job = '0;
        job.last = in_last;
        job.kind = mtae_pkg::JOB_QUIET;
        job.b0 = b;
        span_after = span_reg;
        err_after = err_reg;
        if (err_reg)
        begin
            job.kind = mtae_pkg::JOB_QUIET;
        end
        else if (!in_tag_reg)
        begin
            if (!(b == mtae_pkg::CH_OPEN && !in_last))
            begin
                job.kind = mtae_pkg::JOB_BYTE;
            end
        end
        else if (count_reg == 5'd0 && in_last)
        begin
            job.kind = mtae_pkg::JOB_PAIR;
        end
        else if (count_reg == 5'd0 && b == mtae_pkg::CH_OPEN)
        begin
            job.kind = mtae_pkg::JOB_BYTE;
        end
        else if (b == mtae_pkg::CH_CLOSE)
        begin
            if (!hit)
            begin
                job.kind = mtae_pkg::JOB_STATUS;
                job.err = mtae_pkg::ST_UNKNOWN;
                err_after = 1'b1;
            end
            else if (hit_idx == mtae_pkg::KW_CLOSE && !span_reg)
            begin
                job.kind = mtae_pkg::JOB_STATUS;
                job.err = mtae_pkg::ST_CLOSE_BAD;
                err_after = 1'b1;
            end
            else
            begin
                span_after = (hit_idx != mtae_pkg::KW_CLOSE);
                job.kind = strip_mode ? mtae_pkg::JOB_QUIET : mtae_pkg::JOB_ESC;
                job.code_len = cdata[34:32];
                job.code = cdata[31:0];
            end
        end
        else if (in_last)
        begin
            job.kind = mtae_pkg::JOB_STATUS;
            job.err = mtae_pkg::ST_UNCLOSED;
            err_after = 1'b1;
        end
        job.open_end = in_last && !err_after && span_after;
    end

    assign job_valid = take;

    always_ff @(posedge clk)
    begin
        if (take && in_tag_reg && !err_reg && count_reg < 5'(mtae_pkg::KW_MAX)
            && b != mtae_pkg::CH_CLOSE && !in_last
            && !(count_reg == 5'd0 && b == mtae_pkg::CH_OPEN))
        begin
            text_reg[count_reg] <= b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            in_tag_reg <= 1'b0;
            span_reg <= 1'b0;
            err_reg <= 1'b0;
        end
        else if (take)
        begin
            if (in_last)
            begin
                count_reg <= '0;
                in_tag_reg <= 1'b0;
                span_reg <= 1'b0;
                err_reg <= 1'b0;
            end
            else if (err_reg)
            begin
            end
            else if (!in_tag_reg)
            begin
                if (b == mtae_pkg::CH_OPEN)
                begin
                    in_tag_reg <= 1'b1;
                    count_reg <= '0;
                end
            end
            else if (count_reg == 5'd0 && b == mtae_pkg::CH_OPEN)
            begin
                in_tag_reg <= 1'b0;
            end
            else if (b == mtae_pkg::CH_CLOSE)
            begin
                in_tag_reg <= 1'b0;
                count_reg <= '0;
                if (!hit || (hit_idx == mtae_pkg::KW_CLOSE && !span_reg))
                begin
                    err_reg <= 1'b1;
                end
                else
                begin
                    span_reg <= (hit_idx != mtae_pkg::KW_CLOSE);
                end
            end
            else if (count_reg <= 5'(mtae_pkg::KW_MAX))
            begin
                count_reg <= count_reg + 5'd1;
            end
        end
    end

`ifndef SYNTH
    a_count_sat: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 5'(mtae_pkg::KW_MAX + 1))
        else $error("tag count beyond saturation");
    a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (take && in_last) |=> (!in_tag_reg && !span_reg && !err_reg))
        else $error("message state not cleared");
    a_no_tag_err: assert property (@(posedge clk) disable iff (!rst_n)
        err_reg |-> !in_tag_reg)
        else $error("tag open after error");
`endif

endmodule
`default_nettype wire

// ===== rtl/mtae_back.sv =====
`default_nettype none
module mtae_back #(
    parameter int DEPTH = 4
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               job_valid,
    input  wire mtae_pkg::mtae_job_t job,
    output logic                    job_full,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [15:0]             out_data,
    output logic [3:0]              out_user,
    output logic                    out_last
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    mtae_pkg::mtae_job_t q_reg [DEPTH];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0]   n_reg;
    logic [2:0]    pos_reg;
    mtae_pkg::mtae_job_t h;
    logic [3:0]    total;
    logic [7:0]    ob;
    logic          bv;
    logic [2:0]    st;
    logic          pop, adv;

    assign h = q_reg[rp_reg];
    assign job_full = (n_reg == (AW+1)'(DEPTH));

    always_comb
    begin
        logic [2:0] nb;
        logic [1:0] ci;
        ci = 2'(pos_reg - 3'd2);
        case (h.kind)
            mtae_pkg::JOB_BYTE:   nb = 3'd1;
            mtae_pkg::JOB_PAIR:   nb = 3'd2;
            mtae_pkg::JOB_ESC:    nb = 3'd3 + h.code_len;
            mtae_pkg::JOB_STATUS: nb = 3'd0;
            default:              nb = 3'd0;
        endcase
        total = 4'(nb) + 4'(h.open_end) + 4'(h.kind == mtae_pkg::JOB_STATUS);
        ob = 8'h00;
        bv = 1'b0;
        st = mtae_pkg::ST_OK;
        if (pos_reg < nb)
        begin
            bv = 1'b1;
            case (h.kind)
                mtae_pkg::JOB_BYTE: ob = h.b0;
                mtae_pkg::JOB_PAIR: ob = (pos_reg == 3'd0) ? mtae_pkg::CH_OPEN : h.b0;
                default:
                begin
                    if (pos_reg == 3'd0)
                        ob = mtae_pkg::CH_ESC;
                    else if (pos_reg == 3'd1)
                        ob = mtae_pkg::CH_OPEN;
                    else if (pos_reg == nb - 3'd1)
                        ob = mtae_pkg::CH_M;
                    else
                        ob = h.code[{ci, 3'b000} +: 8];
                end
            endcase
        end
        else if (h.kind == mtae_pkg::JOB_STATUS)
        begin
            st = h.err;
        end
        else if (h.open_end)
        begin
            st = mtae_pkg::ST_OPEN_END;
        end
        if (total == 4'd0 && h.last)
        begin
            total = 4'd1;
        end
    end

    // Jobs with no result at all leave the queue without a transfer.
    assign out_valid = (n_reg != '0) && (total != 4'd0);
    assign adv = out_valid && out_ready;
    assign out_last = ({1'b0, pos_reg} == total - 4'd1);
    assign pop = (n_reg != '0) && ((total == 4'd0) || (adv && out_last));
    assign out_data = {7'b0000000, h.last, ob};
    assign out_user = {st, bv};

    always_ff @(posedge clk)
    begin
        if (job_valid)
        begin
            q_reg[wp_reg] <= job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            n_reg <= '0;
            pos_reg <= '0;
        end
        else
        begin
            if (job_valid)
                wp_reg <= (wp_reg == AW'(DEPTH - 1)) ? '0 : wp_reg + AW'(1);
            if (pop)
                rp_reg <= (rp_reg == AW'(DEPTH - 1)) ? '0 : rp_reg + AW'(1);
            n_reg <= n_reg + (AW+1)'(job_valid) - (AW+1)'(pop);
            if (pop)
                pos_reg <= '0;
            else if (adv)
                pos_reg <= pos_reg + 3'd1;
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        job_full |-> !job_valid)
        else $error("queue overflow");
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ({1'b0, pos_reg} < total))
        else $error("burst position out of range");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= (AW+1)'(DEPTH))
        else $error("queue count out of range");
`endif

endmodule
`default_nettype wire
